### hw/rtl/serial_tty_rx_tx_ring_buffers_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial tty ring buffer block
// Clocked implication checks with reset disable, same-cycle and next-cycle.
// ----------------------------------------------------------------------------
`ifndef SERIAL_TTY_RX_TX_RING_BUFFERS_TOP_DEFINES_SVH
`define SERIAL_TTY_RX_TX_RING_BUFFERS_TOP_DEFINES_SVH

// Same-cycle implication
`define SRB_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srb assertion failed (same cycle)");

// Next-cycle implication
`define SRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srb assertion failed (next cycle)");

`endif

### hw/rtl/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Types and character constants for the serial tty ring buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

    // Event codes of one input item
    typedef enum logic [1:0] {
        MODE_RX_BYTE  = 2'd0,
        MODE_POP      = 2'd1,
        MODE_PUSH     = 2'd2,
        MODE_TX_READY = 2'd3
    } t_mode;

    // Control sequencer
    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    localparam logic [6:0] RX_MASK   = 7'h7F;
    localparam logic [6:0] CHAR_CR   = 7'h0D;
    localparam logic [6:0] CHAR_LF   = 7'h0A;
    localparam logic [7:0] CHAR_BELL = 8'h07;

endpackage

`default_nettype wire

### hw/rtl/srb_ram.sv
// ----------------------------------------------------------------------------
// srb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hw/rtl/serial_tty_rx_tx_ring_buffers_top.sv
// A received byte, a push, an empty pop or a transmitter-ready on an empty
// ring shows its result in the cycle after acceptance; the next item may
// follow in the next cycle when the output is ready. A ring-reading pop or
// transmitter-ready waits in the read state for the registered RAM data.
// Reset clears pointers, fill counts and the transmit interrupt enable; the
// ring RAM contents are not cleared.
`default_nettype none

`include "serial_tty_rx_tx_ring_buffers_top_defines.svh"

// ----------------------------------------------------------------------------
// serial_tty_rx_tx_ring_buffers_top
// Receive and transmit rings for one serial line, with input echo and bell.
// ----------------------------------------------------------------------------
module serial_tty_rx_tx_ring_buffers_top #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_data_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_line_valid,
    output logic      [7:0] o_line_byte,
    output logic            o_read_valid,
    output logic      [6:0] o_read_byte,
    output logic            o_push_accepted,
    output logic            o_tx_irq_enabled,
    output logic      [6:0] o_rx_count,
    output logic      [6:0] o_tx_count
);

    import srb_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] FULL_FILL = CW'(RING_DEPTH);

    // Control state
    t_state        r_state, n_state;
    logic          r_pend_tx, n_pend_tx;
    logic [PW-1:0] r_rx_wr_ptr, n_rx_wr_ptr, r_rx_rd_ptr, n_rx_rd_ptr;
    logic [PW-1:0] r_tx_wr_ptr, n_tx_wr_ptr, r_tx_rd_ptr, n_tx_rd_ptr;
    logic [CW-1:0] r_rx_fill, n_rx_fill, r_tx_fill, n_tx_fill;
    logic          r_tx_irq, n_tx_irq;
    logic          r_out_valid, n_out_valid;

    // Result register
    logic       r_line_valid, n_line_valid;
    logic [7:0] r_line_byte, n_line_byte;
    logic       r_read_valid, n_read_valid;
    logic [6:0] r_read_byte, n_read_byte;
    logic       r_push_ok, n_push_ok;
    logic       r_irq_out, n_irq_out;
    logic [6:0] r_rx_count, n_rx_count;
    logic [6:0] r_tx_count, n_tx_count;

    // RAM ports
    logic       rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
    logic [6:0] rx_wr_data, rx_rd_data;
    logic [7:0] tx_rd_data;
    logic [6:0] rx_char;

    logic accept;
    logic out_free;
    logic load_out;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    srb_ram #(.WIDTH(7), .DEPTH(RING_DEPTH)) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rx_wr_en),
        .i_wr_addr (r_rx_wr_ptr),
        .i_wr_data (rx_wr_data),
        .i_rd_en   (rx_rd_en),
        .i_rd_addr (r_rx_rd_ptr),
        .o_rd_data (rx_rd_data)
    );

    srb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tx_wr_en),
        .i_wr_addr (r_tx_wr_ptr),
        .i_wr_data (i_data_byte),
        .i_rd_en   (tx_rd_en),
        .i_rd_addr (r_tx_rd_ptr),
        .o_rd_data (tx_rd_data)
    );

    // Fold carriage return into line feed after masking to 7 bits
    assign rx_char    = i_data_byte[6:0] & RX_MASK;
    assign rx_wr_data = (rx_char == CHAR_CR) ? CHAR_LF : rx_char;

    // Decode the item, update the rings and build the result.
    // Each item touches one RAM once, so a write and a read of the same
    // entry never fall in one cycle and no forwarding is needed.
    always_comb begin
        n_state     = r_state;
        n_pend_tx   = r_pend_tx;
        n_rx_wr_ptr = r_rx_wr_ptr;
        n_rx_rd_ptr = r_rx_rd_ptr;
        n_tx_wr_ptr = r_tx_wr_ptr;
        n_tx_rd_ptr = r_tx_rd_ptr;
        n_rx_fill   = r_rx_fill;
        n_tx_fill   = r_tx_fill;
        n_tx_irq    = r_tx_irq;
        rx_wr_en    = 1'b0;
        rx_rd_en    = 1'b0;
        tx_wr_en    = 1'b0;
        tx_rd_en    = 1'b0;
        load_out    = 1'b0;

        n_line_valid = 1'b0;
        n_line_byte  = 8'h00;
        n_read_valid = 1'b0;
        n_read_byte  = 7'h00;
        n_push_ok    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_mode'(i_mode))
                        MODE_RX_BYTE: begin
                            load_out     = 1'b1;
                            n_line_valid = 1'b1;
                            if (r_rx_fill == FULL_FILL) begin
                                n_line_byte = CHAR_BELL;
                            end else begin
                                n_line_byte = {1'b0, rx_wr_data};
                                rx_wr_en    = 1'b1;
                                n_rx_wr_ptr = (r_rx_wr_ptr == LAST_SLOT) ? '0
                                                                         : r_rx_wr_ptr + 1'b1;
                                n_rx_fill   = r_rx_fill + 1'b1;
                            end
                        end
                        MODE_POP: begin
                            if (r_rx_fill != '0) begin
                                rx_rd_en    = 1'b1;
                                n_rx_rd_ptr = (r_rx_rd_ptr == LAST_SLOT) ? '0
                                                                         : r_rx_rd_ptr + 1'b1;
                                n_rx_fill   = r_rx_fill - 1'b1;
                                n_pend_tx   = 1'b0;
                                n_state     = S_READ;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        MODE_PUSH: begin
                            load_out = 1'b1;
                            if (r_tx_fill != FULL_FILL) begin
                                n_push_ok   = 1'b1;
                                tx_wr_en    = 1'b1;
                                n_tx_wr_ptr = (r_tx_wr_ptr == LAST_SLOT) ? '0
                                                                         : r_tx_wr_ptr + 1'b1;
                                n_tx_fill   = r_tx_fill + 1'b1;
                                n_tx_irq    = 1'b1;
                            end
                        end
                        MODE_TX_READY: begin
                            if (r_tx_fill == '0) begin
                                load_out = 1'b1;
                                n_tx_irq = 1'b0;
                            end else begin
                                tx_rd_en    = 1'b1;
                                n_tx_rd_ptr = (r_tx_rd_ptr == LAST_SLOT) ? '0
                                                                         : r_tx_rd_ptr + 1'b1;
                                n_tx_fill   = r_tx_fill - 1'b1;
                                n_pend_tx   = 1'b1;
                                n_state     = S_READ;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                // Output slot is empty here: it was free at acceptance
                load_out = 1'b1;
                n_state  = S_IDLE;
                if (r_pend_tx) begin
                    n_line_valid = 1'b1;
                    n_line_byte  = tx_rd_data;
                end else begin
                    n_read_valid = 1'b1;
                    n_read_byte  = rx_rd_data & RX_MASK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_irq_out  = n_tx_irq;
        n_rx_count = 7'(n_rx_fill);
        n_tx_count = 7'(n_tx_fill);

        // Hold the result until taken
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_tx   <= 1'b0;
            r_rx_wr_ptr <= '0;
            r_rx_rd_ptr <= '0;
            r_tx_wr_ptr <= '0;
            r_tx_rd_ptr <= '0;
            r_rx_fill   <= '0;
            r_tx_fill   <= '0;
            r_tx_irq    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend_tx   <= n_pend_tx;
            r_rx_wr_ptr <= n_rx_wr_ptr;
            r_rx_rd_ptr <= n_rx_rd_ptr;
            r_tx_wr_ptr <= n_tx_wr_ptr;
            r_tx_rd_ptr <= n_tx_rd_ptr;
            r_rx_fill   <= n_rx_fill;
            r_tx_fill   <= n_tx_fill;
            r_tx_irq    <= n_tx_irq;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_line_valid <= n_line_valid;
            r_line_byte  <= n_line_byte;
            r_read_valid <= n_read_valid;
            r_read_byte  <= n_read_byte;
            r_push_ok    <= n_push_ok;
            r_irq_out    <= n_irq_out;
            r_rx_count   <= n_rx_count;
            r_tx_count   <= n_tx_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_line_valid     = r_line_valid;
    assign o_line_byte      = r_line_byte;
    assign o_read_valid     = r_read_valid;
    assign o_read_byte      = r_read_byte;
    assign o_push_accepted  = r_push_ok;
    assign o_tx_irq_enabled = r_irq_out;
    assign o_rx_count       = r_rx_count;
    assign o_tx_count       = r_tx_count;

    // Checks
    `SRB_ASSERT_NOW(a_rx_fill_bound, i_clk, i_rst_n, 1'b1, r_rx_fill <= FULL_FILL)
    `SRB_ASSERT_NOW(a_tx_fill_bound, i_clk, i_rst_n, 1'b1, r_tx_fill <= FULL_FILL)
    `SRB_ASSERT_NOW(a_read_slot_free, i_clk, i_rst_n, r_state == S_READ, !r_out_valid)
    `SRB_ASSERT_NEXT(a_read_loads, i_clk, i_rst_n, r_state == S_READ, r_out_valid)
    `SRB_ASSERT_NEXT(a_push_irq, i_clk, i_rst_n, tx_wr_en, r_tx_irq && r_tx_fill != '0)

endmodule

`default_nettype wire

### sim/serial_tty_rx_tx_ring_buffers_top_tb.sv
// ----------------------------------------------------------------------------
// serial_tty_rx_tx_ring_buffers_top_tb
// Drives received bytes, reader pops, writer pushes and transmitter-ready
// events into the tty ring buffer block. A local model of both rings predicts
// every result item, and each item the block returns is compared field by
// field. Both handshake sides idle at random. Directed tests cover the empty
// and full rings and the echo rules, and biased random traffic fills the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_tty_rx_tx_ring_buffers_top_tb;

    import srb_pkg::*;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    // One result item of the block
    typedef struct packed {
        logic       line_valid;
        logic [7:0] line_byte;
        logic       read_valid;
        logic [6:0] read_byte;
        logic       push_accepted;
        logic       tx_irq_enabled;
        logic [6:0] rx_count;
        logic [6:0] tx_count;
    } tty_result_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [1:0] i_mode;
    logic [7:0] i_data_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_line_valid;
    logic [7:0] o_line_byte;
    logic       o_read_valid;
    logic [6:0] o_read_byte;
    logic       o_push_accepted;
    logic       o_tx_irq_enabled;
    logic [6:0] o_rx_count;
    logic [6:0] o_tx_count;

    // Local copy of the ring state
    logic [6:0] rx_ring [RING_DEPTH];
    logic [7:0] tx_ring [RING_DEPTH];
    int         rx_wr_idx;
    int         rx_rd_idx;
    int         rx_fill;
    int         tx_wr_idx;
    int         tx_rd_idx;
    int         tx_fill;
    logic       tx_irq_on;

    tty_result_t expected_tty_q[$];
    int          error_count;
    int          cycle_count;
    bit          idling_on;
    int          stall_left;

    serial_tty_rx_tx_ring_buffers_top #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_valid    (o_line_valid),
        .o_line_byte     (o_line_byte),
        .o_read_valid    (o_read_valid),
        .o_read_byte     (o_read_byte),
        .o_push_accepted (o_push_accepted),
        .o_tx_irq_enabled(o_tx_irq_enabled),
        .o_rx_count      (o_rx_count),
        .o_tx_count      (o_tx_count)
    );

    // Generate a 10-unit clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t timeout with %0d items outstanding", $time,
                     expected_tty_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Compute the result of one event and advance the local rings
    function automatic tty_result_t predict_tty_step(t_mode m, logic [7:0] b);
        tty_result_t r;
        logic [6:0]  c;
        r = '0;
        c = b[6:0] & RX_MASK;
        case (m)
            MODE_RX_BYTE: begin
                r.line_valid = 1'b1;
                if (rx_fill >= RING_DEPTH) begin
                    r.line_byte = CHAR_BELL;
                end else begin
                    if (c == CHAR_CR)
                        c = CHAR_LF;
                    r.line_byte = {1'b0, c};
                    rx_ring[rx_wr_idx] = c;
                    rx_wr_idx = (rx_wr_idx + 1) % RING_DEPTH;
                    rx_fill++;
                end
            end
            MODE_POP: begin
                if (rx_fill != 0) begin
                    r.read_valid = 1'b1;
                    r.read_byte = rx_ring[rx_rd_idx];
                    rx_rd_idx = (rx_rd_idx + 1) % RING_DEPTH;
                    rx_fill--;
                end
            end
            MODE_PUSH: begin
                if (tx_fill < RING_DEPTH) begin
                    r.push_accepted = 1'b1;
                    tx_ring[tx_wr_idx] = b;
                    tx_wr_idx = (tx_wr_idx + 1) % RING_DEPTH;
                    tx_fill++;
                    tx_irq_on = 1'b1;
                end
            end
            default: begin
                if (tx_fill == 0) begin
                    tx_irq_on = 1'b0;
                end else begin
                    r.line_valid = 1'b1;
                    r.line_byte = tx_ring[tx_rd_idx];
                    tx_rd_idx = (tx_rd_idx + 1) % RING_DEPTH;
                    tx_fill--;
                end
            end
        endcase
        r.tx_irq_enabled = tx_irq_on;
        r.rx_count = 7'(rx_fill);
        r.tx_count = 7'(tx_fill);
        return r;
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
            error_count++;
        end
    endfunction

    // Compare each returned item with the oldest prediction
    always @(posedge i_clk) begin
        tty_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tty_q.size() == 0) begin
                $display("%0t result item with nothing expected", $time);
                error_count++;
            end else begin
                want = expected_tty_q.pop_front();
                check_field("line_valid", want.line_valid, o_line_valid);
                check_field("line_byte", want.line_byte, o_line_byte);
                check_field("read_valid", want.read_valid, o_read_valid);
                check_field("read_byte", want.read_byte, o_read_byte);
                check_field("push_accepted", want.push_accepted, o_push_accepted);
                check_field("tx_irq_enabled", want.tx_irq_enabled, o_tx_irq_enabled);
                check_field("rx_count", want.rx_count, o_rx_count);
                check_field("tx_count", want.tx_count, o_tx_count);
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one item; call at a falling edge, return at a falling edge
    task automatic send_item(t_mode m, logic [7:0] b);
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        expected_tty_q.push_back(predict_tty_step(m, b));
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted item has come back
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (expected_tty_q.size() != 0);
    endtask

    function automatic logic [7:0] rand_rx_byte();
        if ($urandom_range(0, 15) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'h8D : 8'h0D;
        return 8'($urandom_range(0, 255));
    endfunction

    // Favor one event kind, or none, so the rings reach full and empty
    function automatic t_mode pick_mode(int bias);
        if (bias < 4 && $urandom_range(0, 9) < 6)
            return t_mode'(bias);
        return t_mode'($urandom_range(0, 3));
    endfunction

    task automatic test_empty_rings();
        send_item(MODE_POP, 8'hFF);
        send_item(MODE_TX_READY, 8'hFF);
        send_item(MODE_POP, 8'h00);
        send_item(MODE_TX_READY, 8'h00);
    endtask

    task automatic test_tx_path();
        send_item(MODE_PUSH, 8'h00);
        send_item(MODE_PUSH, 8'hFF);
        send_item(MODE_PUSH, 8'h80);
        send_item(MODE_TX_READY, 8'h55);
        send_item(MODE_TX_READY, 8'hAA);
        send_item(MODE_TX_READY, 8'h00);
        send_item(MODE_TX_READY, 8'h00);
    endtask

    task automatic test_rx_echo();
        send_item(MODE_RX_BYTE, 8'h0D);
        send_item(MODE_RX_BYTE, 8'h8D);
        send_item(MODE_RX_BYTE, 8'hFF);
        send_item(MODE_RX_BYTE, 8'h00);
        send_item(MODE_RX_BYTE, 8'h80);
        send_item(MODE_RX_BYTE, 8'h0A);
        send_item(MODE_RX_BYTE, 8'h07);
        repeat (8)
            send_item(MODE_POP, 8'($urandom_range(0, 255)));
    endtask

    // Fill the receive ring past full, then drain it past empty
    task automatic test_rx_overflow();
        repeat (RING_DEPTH + 3)
            send_item(MODE_RX_BYTE, rand_rx_byte());
        repeat (RING_DEPTH + 2)
            send_item(MODE_POP, 8'($urandom_range(0, 255)));
    endtask

    // Fill the transmit ring past full, then send it out past empty
    task automatic test_tx_overflow();
        repeat (RING_DEPTH + 3)
            send_item(MODE_PUSH, 8'($urandom_range(0, 255)));
        repeat (RING_DEPTH + 2)
            send_item(MODE_TX_READY, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_mix(int count);
        int    left;
        int    bias;
        int    run_len;
        t_mode m;
        left = count;
        while (left > 0) begin
            bias = $urandom_range(0, 4);
            run_len = $urandom_range(10, 60);
            while (run_len > 0 && left > 0) begin
                m = pick_mode(bias);
                send_item(m, (m == MODE_RX_BYTE) ? rand_rx_byte()
                                                 : 8'($urandom_range(0, 255)));
                run_len--;
                left--;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_RX_BYTE;
        i_data_byte = 8'h00;
        i_out_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stall_left = 0;
        idling_on = 1'b1;
        rx_wr_idx = 0;
        rx_rd_idx = 0;
        rx_fill = 0;
        tx_wr_idx = 0;
        tx_rd_idx = 0;
        tx_fill = 0;
        tx_irq_on = 1'b0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_rings();
        test_tx_path();
        test_rx_echo();
        wait_drain();
        test_rx_overflow();
        test_tx_overflow();
        test_random_mix(450);

        // Run the last part without idling on either side
        idling_on = 1'b0;
        test_random_mix(150);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### serial_tty_rx_tx_ring_buffers_top.f
+incdir+hw/rtl
hw/rtl/srb_pkg.sv
hw/rtl/srb_ram.sv
hw/rtl/serial_tty_rx_tx_ring_buffers_top.sv
sim/serial_tty_rx_tx_ring_buffers_top_tb.sv
